// File: hw/rtl/dtiu_pkg.sv
// shared types and constants of the dual timer interrupt unit
`timescale 1ns / 1ps

package dtiu_pkg;

  // command codes carried in tuser
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned RegNum = 16;

  // register map
  localparam logic [AddrW-1:0] ADDR_TA_LO  = 4'd4;
  localparam logic [AddrW-1:0] ADDR_TA_HI  = 4'd5;
  localparam logic [AddrW-1:0] ADDR_TB_LO  = 4'd6;
  localparam logic [AddrW-1:0] ADDR_TB_HI  = 4'd7;
  localparam logic [AddrW-1:0] ADDR_STATUS = 4'd13;
  localparam logic [AddrW-1:0] ADDR_CTRL_A = 4'd14;
  localparam logic [AddrW-1:0] ADDR_CTRL_B = 4'd15;

  // control and status bit positions
  localparam int unsigned CtrlEnBit      = 0;
  localparam int unsigned CtrlOneShotBit = 3;
  localparam int unsigned CtrlLoadBit    = 4;
  localparam int unsigned StFlagABit     = 0;
  localparam int unsigned StFlagBBit     = 1;
  localparam int unsigned StMasterBit    = 7;

  // control B input mode field, bits 6:5, value selecting timer A underflows
  localparam logic [1:0] IN_MODE_UFLOW_A = 2'b10;

  // one input item
  typedef struct packed {
    logic [1:0]       cmd;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } in_item_t;

  // result of one timer for one tick
  typedef struct packed {
    logic [CountW-1:0] count;
    logic              underflow;
    logic              stop;
  } tmr_res_t;

endpackage

// File: hw/rtl/dtiu_in_stage.sv
// input register of the dual timer interrupt unit
`timescale 1ns / 1ps

module dtiu_in_stage
  import dtiu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [1:0] s_axis_tuser,   // command[1:0]
  input  logic [15:0] s_axis_tdata,  // addr[3:0], wdata[11:4], zero[15:12]
  input  logic       advance_i,
  output logic       valid_o,
  output in_item_t   item_o
);

  logic     valid_q;
  in_item_t item_q;

  // free when empty or when the held item moves on this cycle
  assign s_axis_tready = !valid_q || advance_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.cmd   <= s_axis_tuser;
      item_q.addr  <= s_axis_tdata[AddrW-1:0];
      item_q.wdata <= s_axis_tdata[AddrW+DataW-1:AddrW];
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hw/rtl/dtiu_timer_step.sv
// one tick of one down-counting timer
`timescale 1ns / 1ps

module dtiu_timer_step
  import dtiu_pkg::*;
(
  input  logic              run_i,
  input  logic              oneshot_i,
  input  logic [CountW-1:0] count_i,
  input  logic [CountW-1:0] latch_i,
  output tmr_res_t          res_o
);

  logic [CountW-1:0] dec;
  logic              hit_zero;

  assign dec      = count_i - CountW'(1);
  assign hit_zero = run_i && (count_i == CountW'(1));

  // decrement, then reload or stop when zero is reached
  always_comb begin
    res_o.underflow = hit_zero;
    res_o.stop      = hit_zero && oneshot_i;
    if (!run_i || count_i == '0) begin
      res_o.count = count_i;
    end else if (hit_zero && !oneshot_i) begin
      res_o.count = latch_i;
    end else begin
      res_o.count = dec;
    end
  end

endmodule

// File: hw/rtl/dtiu_core.sv
// register file, timers and interrupt state, one item per fire
`timescale 1ns / 1ps

module dtiu_core
  import dtiu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  in_item_t         item_i,
  output logic [DataW-1:0] rdata_o,
  output logic             irq_o
);

  logic [DataW-1:0]  rf_q [RegNum];
  logic [DataW-1:0]  rf_d [RegNum];
  logic [CountW-1:0] latch_a_q, latch_a_d, latch_b_q, latch_b_d;
  logic [CountW-1:0] count_a_q, count_a_d, count_b_q, count_b_d;
  logic              irq_q, irq_d;

  logic [DataW-1:0] ctrl_a, ctrl_b, status;
  logic [DataW-1:0] status_a;
  logic             run_a, run_b;
  tmr_res_t         res_a, res_b;

  assign ctrl_a = rf_q[ADDR_CTRL_A];
  assign ctrl_b = rf_q[ADDR_CTRL_B];
  assign status = rf_q[ADDR_STATUS];

  // timer A runs first, its flag may gate timer B
  assign run_a    = ctrl_a[CtrlEnBit];
  assign status_a = status | (res_a.underflow ? DataW'(1 << StFlagABit) : '0);
  assign run_b    = ctrl_b[CtrlEnBit] &&
                    ((ctrl_b[6:5] != IN_MODE_UFLOW_A) || status_a[StFlagABit]);

  dtiu_timer_step u_step_a (
    .run_i     (run_a),
    .oneshot_i (ctrl_a[CtrlOneShotBit]),
    .count_i   (count_a_q),
    .latch_i   (latch_a_q),
    .res_o     (res_a)
  );

  dtiu_timer_step u_step_b (
    .run_i     (run_b),
    .oneshot_i (ctrl_b[CtrlOneShotBit]),
    .count_i   (count_b_q),
    .latch_i   (latch_b_q),
    .res_o     (res_b)
  );

  // next state and read data for the item at hand
  always_comb begin
    logic [CountW-1:0] lat;
    lat       = '0;
    rf_d      = rf_q;
    latch_a_d = latch_a_q;
    latch_b_d = latch_b_q;
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    irq_d     = irq_q;
    rdata_o   = '0;
    unique case (item_i.cmd)
      CMD_TICK: begin
        count_a_d = res_a.count;
        count_b_d = res_b.count;
        rf_d[ADDR_STATUS] = status_a |
                            (res_b.underflow ? DataW'(1 << StFlagBBit) : '0);
        if ((res_a.underflow || res_b.underflow) && status[StMasterBit]) begin
          irq_d = 1'b1;
        end
        if (res_a.stop) begin
          rf_d[ADDR_CTRL_A][CtrlEnBit] = 1'b0;
        end
        if (res_b.stop) begin
          rf_d[ADDR_CTRL_B][CtrlEnBit] = 1'b0;
        end
      end
      CMD_READ: begin
        unique case (item_i.addr)
          ADDR_TA_LO: rdata_o = count_a_q[DataW-1:0];
          ADDR_TA_HI: rdata_o = count_a_q[CountW-1:DataW];
          ADDR_TB_LO: rdata_o = count_b_q[DataW-1:0];
          ADDR_TB_HI: rdata_o = count_b_q[CountW-1:DataW];
          ADDR_STATUS: begin
            rdata_o           = status;
            rf_d[ADDR_STATUS] = '0;
            irq_d             = 1'b0;
          end
          default: rdata_o = rf_q[item_i.addr];
        endcase
      end
      CMD_WRITE: begin
        unique case (item_i.addr)
          ADDR_TA_LO: latch_a_d[DataW-1:0] = item_i.wdata;
          ADDR_TA_HI: begin
            lat       = {item_i.wdata, latch_a_q[DataW-1:0]};
            latch_a_d = lat;
            if (!ctrl_a[CtrlEnBit]) begin
              count_a_d = lat;
            end
          end
          ADDR_TB_LO: latch_b_d[DataW-1:0] = item_i.wdata;
          ADDR_TB_HI: begin
            lat       = {item_i.wdata, latch_b_q[DataW-1:0]};
            latch_b_d = lat;
            if (!ctrl_b[CtrlEnBit]) begin
              count_b_d = lat;
            end
          end
          ADDR_STATUS: begin
            // set mode also raises master enable, clear mode keeps it
            if (item_i.wdata[StMasterBit]) begin
              rf_d[ADDR_STATUS] = status | item_i.wdata;
            end else begin
              rf_d[ADDR_STATUS] = status & ~item_i.wdata;
            end
          end
          ADDR_CTRL_A: begin
            rf_d[ADDR_CTRL_A]              = item_i.wdata;
            rf_d[ADDR_CTRL_A][CtrlLoadBit] = 1'b0;
            if (item_i.wdata[CtrlLoadBit]) begin
              count_a_d = latch_a_q;
            end
          end
          ADDR_CTRL_B: begin
            rf_d[ADDR_CTRL_B]              = item_i.wdata;
            rf_d[ADDR_CTRL_B][CtrlLoadBit] = 1'b0;
            if (item_i.wdata[CtrlLoadBit]) begin
              count_b_d = latch_b_q;
            end
          end
          default: rf_d[item_i.addr] = item_i.wdata;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign irq_o = irq_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegNum; i++) begin
        rf_q[i] <= '0;
      end
      latch_a_q <= '0;
      latch_b_q <= '0;
      count_a_q <= '0;
      count_b_q <= '0;
      irq_q     <= 1'b0;
    end else if (fire_i) begin
      rf_q      <= rf_d;
      latch_a_q <= latch_a_d;
      latch_b_q <= latch_b_d;
      count_a_q <= count_a_d;
      count_b_q <= count_b_d;
      irq_q     <= irq_d;
    end
  end

  // interrupt can only be pending with master enable set
  a_irq_master : assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_q |-> status[StMasterBit])
    else $error("irq pending without master enable");

  // force load bits never stay stored
  a_no_load_bit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_a[CtrlLoadBit] && !ctrl_b[CtrlLoadBit])
    else $error("force load bit stored");

  // status read clears status and interrupt
  a_status_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.cmd == CMD_READ && item_i.addr == ADDR_STATUS
    |=> status == '0 && !irq_q)
    else $error("status read did not clear");

  // counters hold when no item is processed
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(count_a_q) && $stable(count_b_q) && $stable(irq_q))
    else $error("state changed without an item");

endmodule

// File: hw/rtl/dual_timer_interrupt_unit.sv
// top level of the dual timer interrupt unit
`timescale 1ns / 1ps

// Two 16-bit down-counting timers with a byte-wide register map and an
// interrupt status byte. Each item is a tick, a register read or a register
// write (command in tuser) and yields exactly one result item with the read
// byte and the interrupt line state after that item. An item passes an input
// register, is processed against the timer and register state, and lands in
// a result register, which holds it until it is taken; one item is accepted per
// cycle as long as the result register is drained. Throughput is set by the
// single result register handshake; command code 3 is accepted and does
// nothing.
module dual_timer_interrupt_unit
  import dtiu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // addr[3:0], wdata[11:4], zero[15:12]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // rdata[7:0], irq_line[8], zero[15:9]
);

  logic             in_valid;
  in_item_t         in_item;
  logic             advance;
  logic [DataW-1:0] rdata_d, rdata_q;
  logic             irq_d, irq_line_q;
  logic             out_valid_q;

  // an item moves on when the result register is empty or being drained
  assign advance = in_valid && (!out_valid_q || m_axis_tready);

  dtiu_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .advance_i     (advance),
    .valid_o       (in_valid),
    .item_o        (in_item)
  );

  dtiu_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .item_i  (in_item),
    .rdata_o (rdata_d),
    .irq_o   (irq_d)
  );

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      rdata_q    <= rdata_d;
      irq_line_q <= irq_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, irq_line_q, rdata_q};

endmodule
